// File: hdl/smx_pkg.sv
package smx_pkg;

   // Storage sizes and derived widths
   localparam int STACK_DEPTH  = 1024;
   localparam int LOCALS_DEPTH = 256;
   localparam int PC_BITS      = 16;
   localparam int DIV_W        = 32;

   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int LA_W  = $clog2(LOCALS_DEPTH);
   localparam int LT_W  = $clog2(LOCALS_DEPTH + 1);

   typedef enum logic [4:0] {
      OP_HALT    = 5'd0,
      OP_CONST   = 5'd1,
      OP_ADD     = 5'd2,
      OP_SUB     = 5'd3,
      OP_MUL     = 5'd4,
      OP_DIV     = 5'd5,
      OP_MOD     = 5'd6,
      OP_LT      = 5'd7,
      OP_LE      = 5'd8,
      OP_GT      = 5'd9,
      OP_GE      = 5'd10,
      OP_EQ      = 5'd11,
      OP_NE      = 5'd12,
      OP_CONSTF  = 5'd13,
      OP_DUP     = 5'd14,
      OP_JMP     = 5'd15,
      OP_JMPT    = 5'd16,
      OP_JMPF    = 5'd17,
      OP_LOAD    = 5'd18,
      OP_STORE   = 5'd19,
      OP_PUSHARG = 5'd20,
      OP_CALL    = 5'd21,
      OP_RET     = 5'd22,
      OP_RETVOID = 5'd23,
      OP_POP     = 5'd24,
      OP_PRINT   = 5'd25,
      OP_PRINTF  = 5'd26
   } opcode_type;

   typedef enum logic [2:0] {
      FAULT_NONE      = 3'd0,
      FAULT_OVERFLOW  = 3'd1,
      FAULT_UNDERFLOW = 3'd2,
      FAULT_DIV_ZERO  = 3'd3,
      FAULT_LOCAL     = 3'd4
   } fault_type;

   typedef enum logic [1:0] {
      PRINT_NONE  = 2'd0,
      PRINT_INT   = 2'd1,
      PRINT_FLOAT = 2'd2
   } print_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_RD3,
      S_EXEC,
      S_DIV,
      S_WR2
   } state_type;

   // Values popped, values present afterwards, instruction length in words
   typedef struct packed {
      logic [1:0] need;
      logic [1:0] push;
      logic [1:0] len;
   } shape_type;

   function automatic shape_type op_shape(input logic [4:0] op);
      shape_type s;
      s.need = 2'd0;
      s.push = 2'd0;
      s.len  = 2'd1;
      case (op) inside
         OP_CONST, OP_CONSTF, OP_LOAD: begin
            s.push = 2'd1;
            s.len  = 2'd2;
         end
         OP_DUP: begin
            s.need = 2'd1;
            s.push = 2'd2;
         end
         OP_JMP: s.len = 2'd2;
         OP_JMPT, OP_JMPF, OP_STORE: begin
            s.need = 2'd1;
            s.len  = 2'd2;
         end
         OP_PUSHARG, OP_POP, OP_PRINT, OP_PRINTF: s.need = 2'd1;
         OP_CALL: begin
            s.push = 2'd2;
            s.len  = 2'd3;
         end
         OP_RET: begin
            s.need = 2'd3;
            s.push = 2'd1;
         end
         OP_RETVOID: s.need = 2'd2;
         [OP_ADD:OP_NE]: begin
            s.need = 2'd2;
            s.push = 2'd1;
         end
         default: ;
      endcase
      return s;
   endfunction

endpackage

// File: hdl/smx_req_if.sv
interface smx_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         mode;
   logic signed [31:0] immediate;
   logic [8:0]         argument_count;

   modport source(output valid, mode, immediate, argument_count, input ready);
   modport sink(input valid, mode, immediate, argument_count, output ready);
endinterface

// File: hdl/smx_rsp_if.sv
interface smx_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        next_pc;
   logic               halted;
   logic [1:0]         print_kind;
   logic signed [31:0] print_value;
   logic [2:0]         fault;

   modport source(output valid, next_pc, halted, print_kind, print_value, fault,
                  input ready);
   modport sink(input valid, next_pc, halted, print_kind, print_value, fault,
                output ready);
endinterface

// File: hdl/smx_div.sv
module smx_div import smx_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [$clog2(DIV_W)-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [DIV_W-1:0]         dsr_ff, dsr_in;
   logic [DIV_W:0]           shifted;
   logic [DIV_W:0]           diff;
   logic                     qbit;

   // One restoring step per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      qbit    = ~diff[DIV_W];
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(DIV_W))'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/stack_machine_executor.sv
// Channel   Port group              Direction  Payload
// request   req_ch (valid/ready)    in         mode, immediate, argument_count
// response  rsp_ch (valid/ready)    out        next_pc, halted, print_kind, print_value, fault
// config    psel/penable/pwrite...  in/out     start_pc at byte address 0
//
// An item passes through accept, first stack read and execute, with one more read step for each stack operand
// past the first; call adds a step for its second stack write.
// Divide and modulo also pass through the bit-serial divider.
// Reset is synchronous; both memories need no clearing pass.
// A waiting response holds the item in the execute or divide step; no new item is taken until it leaves.
module stack_machine_executor import smx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   smx_req_if.sink      req_ch,
   smx_rsp_if.source    rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   state_type state_ff, state_in;

   logic [4:0]         op_ff, op_in;
   logic [31:0]        imm_ff, imm_in;
   logic [8:0]         argc_ff, argc_in;
   logic [31:0]        top_ff, top_in;
   logic [31:0]        sec_ff, sec_in;
   logic [31:0]        thr_ff, thr_in;
   logic [31:0]        wr2_ff, wr2_in;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LT_W-1:0]    ltop_ff, ltop_in;
   logic [LT_W-1:0]    fbase_ff, fbase_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic               halt_ff, halt_in;
   logic [15:0]        start_pc_ff, start_pc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_pc_ff, rsp_pc_in;
   logic               rsp_halt_ff, rsp_halt_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_val_ff, rsp_val_in;
   logic [2:0]         rsp_fault_ff, rsp_fault_in;

   // Memories
   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] local_mem [LOCALS_DEPTH];
   logic [31:0] stk_rd_ff;
   logic [31:0] loc_rd_ff;
   logic             stk_re, stk_we, loc_re, loc_we;
   logic [SA_W-1:0]  stk_raddr, stk_waddr;
   logic [LA_W-1:0]  loc_raddr, loc_waddr;
   logic [31:0]      stk_wdata, loc_wdata;

   // Datapath helpers
   shape_type          shape;
   logic [CNT_W-1:0]   cnt_m1, cnt_m2, cnt_m3;
   logic [CNT_W:0]     cnt_after;
   logic [33:0]        idx_s;
   logic               idx_ok;
   logic [LT_W-1:0]    idx_p1;
   logic [PC_BITS-1:0] pc_adv;
   logic [PC_BITS-1:0] imm_pc;
   logic [2:0]         fault_c;
   logic [31:0]        bin_res;
   logic [31:0]        prod;
   logic               out_free;
   logic               accept;
   logic               csr_we;

   // Divider interface
   logic        div_start, div_done;
   logic        na, nb;
   logic [31:0] div_a, div_b, div_q, div_r, div_res;

   smx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign shape     = op_shape(op_ff);
   assign cnt_m1    = count_ff - 1'b1;
   assign cnt_m2    = count_ff - 2'd2;
   assign cnt_m3    = count_ff - 2'd3;
   assign cnt_after = {1'b0, count_ff} + (CNT_W+1)'(shape.push) - (CNT_W+1)'(shape.need);
   assign idx_s     = 34'(fbase_ff) + {{2{imm_ff[31]}}, imm_ff};
   assign idx_ok    = ~idx_s[33] && (idx_s < 34'(LOCALS_DEPTH));
   assign idx_p1    = idx_s[LT_W-1:0] + 1'b1;
   assign pc_adv    = pc_ff + PC_BITS'(shape.len);
   assign imm_pc    = imm_ff[PC_BITS-1:0];
   assign out_free  = ~rsp_valid_ff | rsp_ch.ready;
   assign accept    = req_ch.valid & req_ch.ready;
   assign csr_we    = psel & penable & pwrite & pready & (paddr == 3'd0);

   // Signed divide operands as magnitudes, sign fixed on the way out
   assign na      = sec_ff[31];
   assign nb      = top_ff[31];
   assign div_a   = na ? (32'd0 - sec_ff) : sec_ff;
   assign div_b   = nb ? (32'd0 - top_ff) : top_ff;
   assign div_res = (op_ff == OP_DIV) ? ((na != nb) ? (32'd0 - div_q) : div_q)
                                      : (na ? (32'd0 - div_r) : div_r);

   // Arithmetic and compares: below-top op top
   assign prod = sec_ff * top_ff;
   always_comb begin
      case (op_ff)
         OP_ADD:  bin_res = sec_ff + top_ff;
         OP_SUB:  bin_res = sec_ff - top_ff;
         OP_MUL:  bin_res = prod;
         OP_LT:   bin_res = 32'($signed(sec_ff) <  $signed(top_ff));
         OP_LE:   bin_res = 32'($signed(sec_ff) <= $signed(top_ff));
         OP_GT:   bin_res = 32'($signed(sec_ff) >  $signed(top_ff));
         OP_GE:   bin_res = 32'($signed(sec_ff) >= $signed(top_ff));
         OP_EQ:   bin_res = 32'(sec_ff == top_ff);
         default: bin_res = 32'(sec_ff != top_ff);
      endcase
   end

   // Fault priority: underflow, overflow, divisor, local range
   always_comb begin
      fault_c = FAULT_NONE;
      if (count_ff < CNT_W'(shape.need))
         fault_c = FAULT_UNDERFLOW;
      else if (cnt_after > (CNT_W+1)'(STACK_DEPTH))
         fault_c = FAULT_OVERFLOW;
      else if ((op_ff == OP_DIV || op_ff == OP_MOD) && top_ff == 32'd0)
         fault_c = FAULT_DIV_ZERO;
      else if (op_ff == OP_LOAD || op_ff == OP_STORE) begin
         if (!idx_ok)
            fault_c = FAULT_LOCAL;
      end else if (op_ff == OP_PUSHARG && ltop_ff >= LT_W'(LOCALS_DEPTH))
         fault_c = FAULT_LOCAL;
      else if (op_ff == OP_CALL && 32'(argc_ff) > 32'(ltop_ff))
         fault_c = FAULT_LOCAL;
      else if ((op_ff == OP_RET && sec_ff > 32'(LOCALS_DEPTH)) ||
               (op_ff == OP_RETVOID && top_ff > 32'(LOCALS_DEPTH)))
         fault_c = FAULT_LOCAL;
   end

   // Sequencer: read operands, execute, write back
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      imm_in       = imm_ff;
      argc_in      = argc_ff;
      top_in       = top_ff;
      sec_in       = sec_ff;
      thr_in       = thr_ff;
      wr2_in       = wr2_ff;
      count_in     = count_ff;
      ltop_in      = ltop_ff;
      fbase_in     = fbase_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      start_pc_in  = start_pc_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_pc_in    = rsp_pc_ff;
      rsp_halt_in  = rsp_halt_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_fault_in = rsp_fault_ff;
      stk_re       = 1'b0;
      stk_raddr    = cnt_m1[SA_W-1:0];
      stk_we       = 1'b0;
      stk_waddr    = count_ff[SA_W-1:0];
      stk_wdata    = top_ff;
      loc_re       = 1'b0;
      loc_raddr    = idx_s[LA_W-1:0];
      loc_we       = 1'b0;
      loc_waddr    = idx_s[LA_W-1:0];
      loc_wdata    = top_ff;
      div_start    = 1'b0;
      req_ch.ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_ch.mode;
               imm_in   = req_ch.immediate;
               argc_in  = req_ch.argument_count;
               stk_re   = 1'b1;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            top_in    = stk_rd_ff;
            loc_re    = 1'b1;
            stk_re    = 1'b1;
            stk_raddr = cnt_m2[SA_W-1:0];
            state_in  = (shape.need >= 2'd2) ? S_RD2 : S_EXEC;
         end
         S_RD2: begin
            sec_in    = stk_rd_ff;
            stk_re    = 1'b1;
            stk_raddr = cnt_m3[SA_W-1:0];
            state_in  = (shape.need >= 2'd3) ? S_RD3 : S_EXEC;
         end
         S_RD3: begin
            thr_in   = stk_rd_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_pc_in    = 16'(pc_ff);
               rsp_halt_in  = halt_ff;
               rsp_kind_in  = PRINT_NONE;
               rsp_val_in   = 32'd0;
               rsp_fault_in = FAULT_NONE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (halt_ff) begin
                  // hold everything once halted
               end else if (fault_c != FAULT_NONE) begin
                  rsp_fault_in = fault_c;
               end else if (op_ff == OP_DIV || op_ff == OP_MOD) begin
                  rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
                  div_start    = 1'b1;
                  state_in     = S_DIV;
               end else begin
                  pc_in = pc_adv;
                  case (op_ff) inside
                     OP_HALT: halt_in = 1'b1;
                     OP_CONST, OP_CONSTF: begin
                        stk_we    = 1'b1;
                        stk_wdata = imm_ff;
                        count_in  = count_ff + 1'b1;
                     end
                     OP_DUP: begin
                        stk_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     OP_JMP: pc_in = imm_pc;
                     OP_JMPT, OP_JMPF: begin
                        count_in = cnt_m1;
                        if ((top_ff != 32'd0) == (op_ff == OP_JMPT))
                           pc_in = imm_pc;
                     end
                     OP_LOAD: begin
                        stk_we    = 1'b1;
                        stk_wdata = loc_rd_ff;
                        count_in  = count_ff + 1'b1;
                     end
                     OP_STORE: begin
                        loc_we   = 1'b1;
                        count_in = cnt_m1;
                        if (idx_p1 > ltop_ff)
                           ltop_in = idx_p1;
                     end
                     OP_PUSHARG: begin
                        loc_we    = 1'b1;
                        loc_waddr = ltop_ff[LA_W-1:0];
                        ltop_in   = ltop_ff + 1'b1;
                        count_in  = cnt_m1;
                     end
                     OP_CALL: begin
                        // push return pc now, saved frame base next cycle
                        stk_we    = 1'b1;
                        stk_wdata = 32'(pc_adv);
                        wr2_in    = 32'(fbase_ff);
                        count_in  = count_ff + 2'd2;
                        fbase_in  = ltop_ff - LT_W'(argc_ff);
                        pc_in     = imm_pc;
                        state_in  = S_WR2;
                     end
                     OP_RET: begin
                        stk_we    = 1'b1;
                        stk_waddr = cnt_m3[SA_W-1:0];
                        ltop_in   = fbase_ff;
                        fbase_in  = sec_ff[LT_W-1:0];
                        pc_in     = thr_ff[PC_BITS-1:0];
                        count_in  = cnt_m2;
                     end
                     OP_RETVOID: begin
                        ltop_in  = fbase_ff;
                        fbase_in = top_ff[LT_W-1:0];
                        pc_in    = sec_ff[PC_BITS-1:0];
                        count_in = cnt_m2;
                     end
                     OP_POP: count_in = cnt_m1;
                     OP_PRINT, OP_PRINTF: begin
                        count_in    = cnt_m1;
                        rsp_val_in  = top_ff;
                        rsp_kind_in = (op_ff == OP_PRINT) ? PRINT_INT : PRINT_FLOAT;
                     end
                     [OP_ADD:OP_NE]: begin
                        stk_we    = 1'b1;
                        stk_waddr = cnt_m2[SA_W-1:0];
                        stk_wdata = bin_res;
                        count_in  = cnt_m1;
                     end
                     default: ;
                  endcase
                  rsp_pc_in   = 16'(pc_in);
                  rsp_halt_in = halt_in;
               end
            end
         end
         S_DIV: begin
            if (div_done && out_free) begin
               stk_we       = 1'b1;
               stk_waddr    = cnt_m2[SA_W-1:0];
               stk_wdata    = div_res;
               count_in     = cnt_m1;
               pc_in        = pc_adv;
               rsp_valid_in = 1'b1;
               rsp_pc_in    = 16'(pc_adv);
               rsp_halt_in  = 1'b0;
               rsp_kind_in  = PRINT_NONE;
               rsp_val_in   = 32'd0;
               rsp_fault_in = FAULT_NONE;
               state_in     = S_IDLE;
            end
         end
         S_WR2: begin
            stk_we    = 1'b1;
            stk_waddr = cnt_m1[SA_W-1:0];
            stk_wdata = wr2_ff;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // Config write reloads the program counter
      if (csr_we) begin
         start_pc_in = pwdata[15:0];
         pc_in       = PC_BITS'(pwdata[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ltop_ff      <= '0;
         fbase_ff     <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         start_pc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ltop_ff      <= ltop_in;
         fbase_ff     <= fbase_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         start_pc_ff  <= start_pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      imm_ff       <= imm_in;
      argc_ff      <= argc_in;
      top_ff       <= top_in;
      sec_ff       <= sec_in;
      thr_ff       <= thr_in;
      wr2_ff       <= wr2_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_halt_ff  <= rsp_halt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // Operand stack memory
   always_ff @(posedge clock) begin
      if (stk_we)
         stack_mem[stk_waddr] <= stk_wdata;
      if (stk_re)
         stk_rd_ff <= stack_mem[stk_raddr];
   end

   // Locals memory
   always_ff @(posedge clock) begin
      if (loc_we)
         local_mem[loc_waddr] <= loc_wdata;
      if (loc_re)
         loc_rd_ff <= local_mem[loc_raddr];
   end

   // Drive ports
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.next_pc     = rsp_pc_ff;
   assign rsp_ch.halted      = rsp_halt_ff;
   assign rsp_ch.print_kind  = rsp_kind_ff;
   assign rsp_ch.print_value = rsp_val_ff;
   assign rsp_ch.fault       = rsp_fault_ff;
   assign prdata             = (paddr == 3'd0) ? 32'(start_pc_ff) : 32'd0;
   assign pready             = 1'b1;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_ltop_range: assert property (@(posedge clock) disable iff (reset)
      ltop_ff <= LT_W'(LOCALS_DEPTH))
      else $error("locals top beyond depth");

   a_fault_no_print: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fault_ff != FAULT_NONE |-> rsp_kind_ff == PRINT_NONE)
      else $error("print reported together with a fault");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");
`endif

endmodule

// File: dv/stack_machine_checker.sv
`timescale 1ns / 1ps

module stack_machine_checker import smx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   smx_req_if          req_ch,
   smx_rsp_if          rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);

   localparam logic [2:0] ADDR_START_PC = 3'd0;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        halted;
      logic [1:0]  print_kind;
      logic [31:0] print_value;
      logic [2:0]  fault;
   } outcome_type;

   // Shadow copy of the machine state
   logic [31:0]    stack_mem [STACK_DEPTH];
   int             depth;
   logic [31:0]    locals_mem [LOCALS_DEPTH];
   int             locals_top;
   int             base_ptr;
   logic [15:0]    pc_reg;
   logic [15:0]    start_pc;
   logic           halt_flag;
   outcome_type    expected_q [$];

   assign pending = expected_q.size();

   // Signed divide through magnitudes, so the most negative value wraps
   function automatic logic [31:0] divide_word(input logic [31:0] a, input logic [31:0] b,
                                               input logic want_rem);
      logic [31:0] ua;
      logic [31:0] ub;
      logic [31:0] q;
      logic [31:0] r;
      ua = a[31] ? 32'd0 - a : a;
      ub = b[31] ? 32'd0 - b : b;
      q  = ua / ub;
      r  = ua % ub;
      if (want_rem) return a[31] ? 32'd0 - r : r;
      return (a[31] != b[31]) ? 32'd0 - q : q;
   endfunction

   function automatic logic [31:0] alu_result(input opcode_type op, input logic [31:0] a,
                                              input logic [31:0] b);
      case (op)
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         OP_DIV: return divide_word(a, b, 1'b0);
         OP_MOD: return divide_word(a, b, 1'b1);
         OP_LT:  return {31'd0, $signed(a) <  $signed(b)};
         OP_LE:  return {31'd0, $signed(a) <= $signed(b)};
         OP_GT:  return {31'd0, $signed(a) >  $signed(b)};
         OP_GE:  return {31'd0, $signed(a) >= $signed(b)};
         OP_EQ:  return {31'd0, a == b};
         default: return {31'd0, a != b};
      endcase
   endfunction

   // Execute one instruction on the shadow state and return its outcome
   task automatic execute_instr(input logic [4:0] mode, input logic [31:0] imm,
                                input logic [8:0] argc, output outcome_type res);
      opcode_type  op;
      int          need;
      int          push;
      int          len;
      fault_type   flt;
      print_type   kind;
      logic [31:0] pval;
      logic [31:0] v;
      logic [15:0] npc;
      longint      idx;
      op   = opcode_type'(mode);
      need = 0;
      push = 0;
      len  = 1;
      flt  = FAULT_NONE;
      kind = PRINT_NONE;
      pval = 32'd0;
      idx  = 0;
      if (!halt_flag) begin
         case (op)
            OP_CONST, OP_CONSTF, OP_LOAD: begin
               push = 1;
               len  = 2;
            end
            OP_DUP: begin
               need = 1;
               push = 2;
            end
            OP_JMP: len = 2;
            OP_JMPT, OP_JMPF, OP_STORE: begin
               need = 1;
               len  = 2;
            end
            OP_PUSHARG, OP_POP, OP_PRINT, OP_PRINTF: need = 1;
            OP_CALL: begin
               push = 2;
               len  = 3;
            end
            OP_RET: begin
               need = 3;
               push = 1;
            end
            OP_RETVOID: need = 2;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_LE, OP_GT, OP_GE,
            OP_EQ, OP_NE: begin
               need = 2;
               push = 1;
            end
            default: ;
         endcase

         // Underflow first, then overflow, then operand-specific checks
         if (depth < need)
            flt = FAULT_UNDERFLOW;
         else if (depth - need + push > STACK_DEPTH)
            flt = FAULT_OVERFLOW;
         else if ((op == OP_DIV || op == OP_MOD) && stack_mem[depth-1] == 32'd0)
            flt = FAULT_DIV_ZERO;
         else if (op == OP_LOAD || op == OP_STORE) begin
            idx = longint'(base_ptr) + longint'($signed(imm));
            if (idx < 0 || idx >= LOCALS_DEPTH) flt = FAULT_LOCAL;
         end else if (op == OP_PUSHARG && locals_top >= LOCALS_DEPTH)
            flt = FAULT_LOCAL;
         else if (op == OP_CALL && int'(argc) > locals_top)
            flt = FAULT_LOCAL;
         else if ((op == OP_RET && stack_mem[depth-2] > LOCALS_DEPTH) ||
                  (op == OP_RETVOID && stack_mem[depth-1] > LOCALS_DEPTH))
            flt = FAULT_LOCAL;

         if (flt == FAULT_NONE) begin
            npc = pc_reg + 16'(len);
            case (op)
               OP_HALT: halt_flag = 1'b1;
               OP_CONST, OP_CONSTF: begin
                  stack_mem[depth] = imm;
                  depth++;
               end
               OP_DUP: begin
                  stack_mem[depth] = stack_mem[depth-1];
                  depth++;
               end
               OP_JMP: npc = imm[15:0];
               OP_JMPT, OP_JMPF: begin
                  depth--;
                  if ((stack_mem[depth] != 0) == (op == OP_JMPT)) npc = imm[15:0];
               end
               OP_LOAD: begin
                  stack_mem[depth] = locals_mem[int'(idx)];
                  depth++;
               end
               OP_STORE: begin
                  depth--;
                  locals_mem[int'(idx)] = stack_mem[depth];
                  if (int'(idx) + 1 > locals_top) locals_top = int'(idx) + 1;
               end
               OP_PUSHARG: begin
                  depth--;
                  locals_mem[locals_top] = stack_mem[depth];
                  locals_top++;
               end
               OP_CALL: begin
                  stack_mem[depth]   = {16'd0, npc};
                  stack_mem[depth+1] = 32'(base_ptr);
                  depth += 2;
                  base_ptr = locals_top - int'(argc);
                  npc = imm[15:0];
               end
               OP_RET, OP_RETVOID: begin
                  v = 32'd0;
                  if (op == OP_RET) begin
                     depth--;
                     v = stack_mem[depth];
                  end
                  locals_top = base_ptr;
                  base_ptr   = int'(stack_mem[depth-1]);
                  npc        = stack_mem[depth-2][15:0];
                  depth -= 2;
                  if (op == OP_RET) begin
                     stack_mem[depth] = v;
                     depth++;
                  end
               end
               OP_POP: depth--;
               OP_PRINT, OP_PRINTF: begin
                  depth--;
                  pval = stack_mem[depth];
                  kind = (op == OP_PRINT) ? PRINT_INT : PRINT_FLOAT;
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_LE, OP_GT, OP_GE,
               OP_EQ, OP_NE: begin
                  stack_mem[depth-2] = alu_result(op, stack_mem[depth-2], stack_mem[depth-1]);
                  depth--;
               end
               default: ;
            endcase
            pc_reg = npc;
         end
      end
      res.next_pc     = pc_reg;
      res.halted      = halt_flag;
      res.print_kind  = kind;
      res.print_value = pval;
      res.fault       = flt;
   endtask

   // Watch all three ports; compare results before queueing new items
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      outcome_type fresh;
      if (reset) begin
         expected_q.delete();
         depth      = 0;
         locals_top = 0;
         base_ptr   = 0;
         start_pc   = 16'd0;
         pc_reg     = 16'd0;
         halt_flag  = 1'b0;
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_START_PC) begin
            start_pc = pwdata[15:0];
            pc_reg   = start_pc;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.next_pc     = rsp_ch.next_pc;
            got.halted      = rsp_ch.halted;
            got.print_kind  = rsp_ch.print_kind;
            got.print_value = rsp_ch.print_value;
            got.fault       = rsp_ch.fault;
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result item: pc=%h halted=%b kind=%0d val=%h fault=%0d",
                           got.next_pc, got.halted, got.print_kind, got.print_value,
                           got.fault);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: exp pc=%h halted=%b kind=%0d val=%h fault=%0d / got pc=%h halted=%b kind=%0d val=%h fault=%0d",
                              want.next_pc, want.halted, want.print_kind, want.print_value,
                              want.fault, got.next_pc, got.halted, got.print_kind,
                              got.print_value, got.fault);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            execute_instr(req_ch.mode, req_ch.immediate, req_ch.argument_count, fresh);
            expected_q.push_back(fresh);
         end
      end
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import smx_pkg::*;

   localparam int         CYCLE_LIMIT   = 3000000;
   localparam int         LONG_HOLD     = 400;
   localparam logic [2:0] ADDR_START_PC = 3'd0;
   localparam logic [4:0] NOP_FIRST     = 5'd27;
   localparam logic [4:0] NOP_LAST      = 5'd31;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;
   int          cycle_count;
   int          hold_left;
   int          rsp_gap;
   bit          stall_request;
   bit          quiet;

   smx_req_if req_ch ();
   smx_rsp_if rsp_ch ();

   stack_machine_executor uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   stack_machine_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // End the run if it stalls
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("stack_machine_executor test failed");
            $finish;
         end
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      rsp_gap      = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rsp_gap = idle_gap();
         end
      end
   end

   // Offer one item; returns at the edge that accepted it
   task automatic send(input logic [4:0] op, input logic [31:0] imm,
                       input logic [8:0] argc = 9'd0);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.mode           <= op;
      req_ch.immediate      <= imm;
      req_ch.argument_count <= argc;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Let the last accepted item be counted, then wait until all results are out
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write with setup and enable phases, issued once the block is idle
   task automatic write_start_pc(input logic [15:0] value);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= ADDR_START_PC;
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic binop_pair(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
      send(OP_CONST, a);
      send(OP_CONST, b);
      send(op, 32'd0);
      send(OP_PRINT, 32'd0);
   endtask

   initial begin
      int sel;
      int n;
      logic [31:0] off;
      logic [4:0]  rop;
      req_ch.valid          = 1'b0;
      req_ch.mode           = 5'd0;
      req_ch.immediate      = 32'd0;
      req_ch.argument_count = 9'd0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = 3'd0;
      pwdata        = 32'd0;
      stall_request = 1'b0;
      quiet         = 1'b0;
      reset         = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every operation but halt, return and jump-if-false, fault cases; start at top of pc range
      write_start_pc(16'hFFFF);
      send(OP_CALL, 32'h0000_0010, 9'd256);
      send(OP_POP, 32'd0);
      send(OP_PUSHARG, 32'd0);
      send(OP_RETVOID, 32'd0);
      binop_pair(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      binop_pair(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      binop_pair(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
      binop_pair(OP_DIV, 32'd5, 32'd0);
      send(OP_POP, 32'd0);
      send(OP_POP, 32'd0);
      for (int o = OP_SUB; o <= OP_NE; o++)
         if (o != OP_DIV && o != OP_MOD) binop_pair(5'(o), 32'hFFFF_FFFF, 32'd1);
      send(OP_CONSTF, 32'h3F80_0000);
      send(OP_DUP, 32'd0);
      send(OP_PRINTF, 32'd0);
      send(OP_PRINTF, 32'd0);
      send(OP_CONST, 32'd7);
      send(OP_STORE, 32'hFFFF_FFFF);
      send(OP_LOAD, 32'd300);
      send(OP_JMPT, 32'd40);
      send(OP_JMP, 32'hFFFF_FFFF);
      send(NOP_LAST, 32'd0);

      // Long result hold-off while items keep coming
      write_start_pc(16'($urandom));
      stall_request = 1'b1;
      for (int i = 0; i < 40; i++) send(OP_CONST, rand_word());
      for (int i = 0; i < 40; i++) send(OP_PRINT, 32'd0);

      // Random sequences, mostly well formed; loads only follow a store to the same local or a call that passed it
      for (int it = 0; it < 90; it++) begin
         if (it == 45) write_start_pc(16'h8000);
         quiet = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 11);
         case (sel)
            0, 1: binop_pair(5'($urandom_range(OP_ADD, OP_NE)), rand_word(),
                             ($urandom_range(0, 5) == 0) ? 32'd0 : rand_word());
            2: begin
               send(OP_CONST, rand_word());
               send(OP_DUP, 32'd0);
               send(OP_ADD, 32'd0);
               send(OP_PRINTF, 32'd0);
            end
            3: begin
               send(OP_CONST, 32'($urandom_range(0, 1)));
               send($urandom_range(0, 1) ? OP_JMPT : OP_JMPF, rand_word());
            end
            4: begin
               off = ($urandom_range(0, 7) == 0) ? rand_word() : 32'($urandom_range(0, 7));
               send(OP_CONST, rand_word());
               send(OP_STORE, off);
               send(OP_LOAD, off);
               send(OP_PRINT, 32'd0);
            end
            5: begin
               send(OP_CONST, rand_word());
               send(OP_PUSHARG, 32'd0);
               send(OP_CALL, rand_word(), 9'd1);
               send(OP_LOAD, 32'd0);
               send(OP_RET, 32'd0);
               send(OP_PRINT, 32'd0);
            end
            6: begin
               send(OP_CALL, rand_word(), 9'd0);
               send(OP_RETVOID, 32'd0);
            end
            7: send(OP_JMP, rand_word());
            8: send(5'($urandom_range(NOP_FIRST, NOP_LAST)), rand_word(),
                    9'($urandom_range(0, 256)));
            default: begin
               n = $urandom_range(1, 3);
               repeat (n) begin
                  rop = 5'($urandom_range(1, 31));
                  if (rop inside {OP_LOAD, OP_RET, OP_RETVOID}) rop = OP_DUP;
                  send(rop, rand_word(), 9'($urandom_range(0, 256)));
               end
            end
         endcase
      end

      // Halt last; later items must be ignored
      quiet = 1'b0;
      send(OP_HALT, 32'd0);
      send(OP_CONST, 32'd1);
      send(OP_PRINT, 32'd0);
      send(OP_JMP, 32'h1234);

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("stack_machine_executor test passed");
      else
         $display("stack_machine_executor test failed");
      $finish;
   end

endmodule

// File: files.f
hdl/smx_pkg.sv
hdl/smx_req_if.sv
hdl/smx_rsp_if.sv
hdl/smx_div.sv
hdl/stack_machine_executor.sv
dv/stack_machine_checker.sv
dv/tb_top.sv
